FILE: rtl/core/acg_pkg.sv
// Shared types and constants for the altitude color gradient core.
// No dependencies; every other file in rtl/core imports this package.
package acg_pkg;

  localparam int COLOR_W     = 24;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int DIV_STEPS   = CHAN_W;          // one quotient bit per stage
  localparam int BLEND_DEPTH = DIV_STEPS + 2;   // product, setup, divide steps

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [CHAN_W-1:0]  chan_t;

  localparam color_t WHITE      = 24'hFFFFFF;
  localparam color_t HIGH_RESET = 24'hFFFFFF;
  localparam color_t LOW_RESET  = 24'h000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_ALT    = 2'd0,
    CFG_MAX_ALT    = 2'd1,
    CFG_LOW_COLOR  = 2'd2,
    CFG_HIGH_COLOR = 2'd3
  } cfg_idx_t;

endpackage

FILE: rtl/core/acg_if.sv
// Valid/ready channel interfaces of the altitude color gradient core.
// Depends on acg_pkg.
interface acg_point_if #(parameter int ALT_BITS = 32);
  import acg_pkg::*;
  logic                valid;
  logic                ready;
  logic [ALT_BITS-1:0] altitude;
  color_t              given_color;
  modport source (output valid, altitude, given_color, input ready);
  modport sink   (input valid, altitude, given_color, output ready);
endinterface

interface acg_color_if;
  import acg_pkg::*;
  logic   valid;
  logic   ready;
  color_t point_color;
  modport source (output valid, point_color, input ready);
  modport sink   (input valid, point_color, output ready);
endinterface

interface acg_cfg_if;
  import acg_pkg::*;
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/altitude_color_gradient_core.sv
// Top level of the altitude color gradient core: config registers, front
// pipeline, three acg_blend channels, output register with skid. Depends on
// acg_pkg, acg_if.sv and acg_blend.
//
//   port   dir    beat contents
//   cfg    sink   index (cfg_idx_t), data (32 bits)
//   point  sink   altitude (ALT_BITS, signed), given_color (24 bits)
//   color  source point_color (24 bits)
//
// One point per cycle sustained while color does not stall.
// The divider has eight stages, one quotient bit per stage.
// rst (synchronous) clears the valid bits and the skid, and resets the config registers (the high color to white).
// A stall on color first parks one result in the skid; point.ready drops only
// once the skid is full, and the whole pipe holds until it drains.
module altitude_color_gradient_core #(
  parameter int ALT_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  acg_cfg_if.sink    cfg,
  acg_point_if.sink  point,
  acg_color_if.source color
);
  import acg_pkg::*;

  localparam int A      = ALT_BITS;
  localparam int FRONT  = 3;
  localparam int LAST   = FRONT + BLEND_DEPTH;   // last stage feeding the output
  localparam int OUT_ST = LAST + 1;

  // configuration
  logic [A-1:0] min_alt;
  logic [A-1:0] max_alt;
  color_t       low_col;
  color_t       high_col;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_alt  <= '0;
      max_alt  <= '0;
      low_col  <= LOW_RESET;
      high_col <= HIGH_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MIN_ALT:    min_alt  <= cfg.data[A-1:0];
        CFG_MAX_ALT:    max_alt  <= cfg.data[A-1:0];
        CFG_LOW_COLOR:  low_col  <= cfg.data[COLOR_W-1:0];
        CFG_HIGH_COLOR: high_col <= cfg.data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic         en;
  logic         skid_v;
  color_t       skid_col;
  logic         vld  [1:OUT_ST];
  logic         byp  [1:LAST];
  color_t       bcol [1:LAST];

  assign en          = !skid_v;
  assign point.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= OUT_ST; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[1] <= point.valid;
      for (int k = 2; k <= OUT_ST; k++) vld[k] <= vld[k-1];
    end
  end

  // stage 1: offsets, pass-through decision
  logic [A-1:0] a_in;
  logic         has_col;
  logic [A:0]   num1, den1;

  assign a_in    = point.altitude[A-1:0];
  assign has_col = (point.given_color != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      num1    <= {a_in[A-1], a_in} - {min_alt[A-1], min_alt};
      den1    <= {max_alt[A-1], max_alt} - {min_alt[A-1], min_alt};
    end
  end

  // stage 2: fold a negative span onto a positive one
  logic [A:0]   num2;
  logic [A-1:0] den2;
  logic [A:0]   num1_neg, den1_neg;

  assign num1_neg = -num1;
  assign den1_neg = -den1;

  always_ff @(posedge clk) begin
    if (en) begin
      num2 <= den1[A] ? num1_neg : num1;
      den2 <= den1[A] ? den1_neg[A-1:0] : den1[A-1:0];
    end
  end

  // stage 3: clamp the fraction to [0,1]
  logic [A-1:0] num3, den3;

  always_ff @(posedge clk) begin
    if (en) begin
      if (num2[A])
        num3 <= '0;
      else if (num2[A-1:0] > den2)
        num3 <= den2;
      else
        num3 <= num2[A-1:0];
      den3 <= den2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byp[1]  <= has_col || (min_alt == max_alt);
      bcol[1] <= has_col ? point.given_color : WHITE;
      for (int k = 2; k <= LAST; k++) begin
        byp[k]  <= byp[k-1];
        bcol[k] <= bcol[k-1];
      end
    end
  end

  // per-channel blend; channel 2 is red
  chan_t q    [NUM_CHAN];
  logic  qneg [NUM_CHAN];
  chan_t lo_c [NUM_CHAN];
  chan_t hi_c [NUM_CHAN];

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    assign lo_c[c] = low_col[c*CHAN_W +: CHAN_W];
    assign hi_c[c] = high_col[c*CHAN_W +: CHAN_W];
    acg_blend #(.ALT_BITS(A)) u_blend (
      .clk  (clk),
      .en   (en),
      .num  (num3),
      .den  (den3),
      .lo_c (lo_c[c]),
      .hi_c (hi_c[c]),
      .quo  (q[c]),
      .dneg (qneg[c])
    );
  end

  // output stage
  color_t blended;
  color_t col_out;

  always_comb begin
    blended = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      blended[c*CHAN_W +: CHAN_W] = qneg[c] ? chan_t'(lo_c[c] - q[c])
                                            : chan_t'(lo_c[c] + q[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) col_out <= byp[LAST] ? bcol[LAST] : blended;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (en && vld[OUT_ST] && !color.ready) begin
      skid_v <= 1'b1;
    end else if (skid_v && color.ready) begin
      skid_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) skid_col <= col_out;
  end

  assign color.valid       = skid_v || vld[OUT_ST];
  assign color.point_color = skid_v ? skid_col : col_out;

  // checks
  a_skid_blocks_input: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> !point.ready)
    else $error("input accepted while skid is full");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    vld[FRONT] && !byp[FRONT] |-> num3 <= den3)
    else $error("fraction numerator above span");

  a_red_in_range: assert property (@(posedge clk) disable iff (rst)
    vld[LAST] && !byp[LAST] |->
      (qneg[NUM_CHAN-1] ? (q[NUM_CHAN-1] <= lo_c[NUM_CHAN-1])
                        : ({1'b0, q[NUM_CHAN-1]} + {1'b0, lo_c[NUM_CHAN-1]}
                           <= {1'b0, 8'hFF})))
    else $error("red blend step overshoots channel range");

endmodule

FILE: rtl/core/acg_blend.sv
// One color channel: scaled product, then an 8-stage restoring divider.
// Gives q = round(num*|hi-lo|/den), ties broken so the blended channel rounds half up. Depends on acg_pkg.
module acg_blend #(
  parameter int ALT_BITS = 32
) (
  input  logic                clk,
  input  logic                en,
  input  logic [ALT_BITS-1:0] num,
  input  logic [ALT_BITS-1:0] den,
  input  acg_pkg::chan_t      lo_c,
  input  acg_pkg::chan_t      hi_c,
  output acg_pkg::chan_t      quo,
  output logic                dneg
);
  import acg_pkg::*;

  localparam int PW = ALT_BITS + CHAN_W;   // product width
  localparam int RW = ALT_BITS + 10;       // dividend: 2p + den < 512*den
  localparam int DW = ALT_BITS + 1;        // divisor 2*den

  logic          dn_cur;
  chan_t         mag;
  logic [PW-1:0] prod;
  logic [ALT_BITS-1:0] den_p;
  logic          dneg_p;

  logic [RW-1:0] rem  [0:DIV_STEPS];
  logic [DW-1:0] dvs  [0:DIV_STEPS];
  chan_t         qb   [0:DIV_STEPS];
  logic          dn   [0:DIV_STEPS];

  assign dn_cur = (hi_c < lo_c);
  assign mag    = dn_cur ? chan_t'(lo_c - hi_c) : chan_t'(hi_c - lo_c);

  // product stage
  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= PW'(num) * PW'(mag);
      den_p  <= den;
      dneg_p <= dn_cur;
    end
  end

  // dividend setup: descending blends round the half down so the sum rounds half up
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'({prod, 1'b0}) + RW'(den_p) - RW'(dneg_p);
      dvs[0] <= {den_p, 1'b0};
      qb[0]  <= '0;
      dn[0]  <= dneg_p;
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
    localparam int K = DIV_STEPS - j;
    logic [RW-1:0] cand;
    logic          ge;
    assign cand = RW'(dvs[j-1]) << K;
    assign ge   = (rem[j-1] >= cand);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= ge ? rem[j-1] - cand : rem[j-1];
        dvs[j] <= dvs[j-1];
        qb[j]  <= {qb[j-1][CHAN_W-2:0], ge};
        dn[j]  <= dn[j-1];
      end
    end
  end

  assign quo  = qb[DIV_STEPS];
  assign dneg = dn[DIV_STEPS];

endmodule
